// ===== sv/srr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_pkg
// Types, codes and helpers shared by the selective repeat receiver files.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int SEQ_W   = 31;
  localparam int CKS_W   = 32;
  localparam int WORD_W  = 64;
  localparam int HIGH_W  = 32;
  localparam int KIND_W  = 2;
  localparam int PART_W  = 13;
  localparam int SLOT_W  = WORD_W + WORD_W + HIGH_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DROP = 2'd2
  } srr_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_FIRST,
    ST_DLV
  } srr_state_t;

  // sum of eight bytes taken as signed chars
  function automatic logic signed [PART_W-1:0] byte_sum8(input logic [WORD_W-1:0] word);
    logic signed [PART_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + PART_W'($signed(word[8*i +: 8]));
    end
    return s;
  endfunction

  function automatic logic signed [PART_W-1:0] byte_sum4(input logic [HIGH_W-1:0] word);
    logic signed [PART_W-1:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s = s + PART_W'($signed(word[8*i +: 8]));
    end
    return s;
  endfunction

endpackage

// ===== sv/srr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_if
// Packet input and result output channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srr_in_if;
  import srr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SEQ_W-1:0]         seq_number;
  logic signed [CKS_W-1:0]  ack_number;
  logic signed [CKS_W-1:0]  packet_checksum;
  logic [WORD_W-1:0]        payload_low;
  logic [WORD_W-1:0]        payload_mid;
  logic [HIGH_W-1:0]        payload_high;

  modport source (
    output valid, seq_number, ack_number, packet_checksum,
           payload_low, payload_mid, payload_high,
    input  ready
  );

  modport sink (
    input  valid, seq_number, ack_number, packet_checksum,
           payload_low, payload_mid, payload_high,
    output ready
  );
endinterface

interface srr_out_if;
  import srr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        result_kind;
  logic [SEQ_W-1:0]         result_seq;
  logic signed [CKS_W-1:0]  ack_checksum;
  logic [WORD_W-1:0]        out_payload_low;
  logic [WORD_W-1:0]        out_payload_mid;
  logic [HIGH_W-1:0]        out_payload_high;
  logic                     last_of_run;

  modport source (
    output valid, result_kind, result_seq, ack_checksum,
           out_payload_low, out_payload_mid, out_payload_high, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, result_kind, result_seq, ack_checksum,
           out_payload_low, out_payload_mid, out_payload_high, last_of_run,
    output ready
  );
endinterface

// ===== sv/selective_repeat_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Checks each packet, acknowledges it, stores it in a reorder slot memory and
// delivers the in-order run from the expected sequence number.
// ----------------------------------------------------------------------------
// the first result is registered after the packet passes ST_SUM and ST_CHECK and
// is pushed from ST_FIRST; a packet gives up to WINDOW+1 results, one result per cycle
//   while the output is not stalled, set by the single read port of the slot memory
// one packet in flight; a new packet is taken once its last result is queued
// reset clears state, expected sequence, slot pointer, slot valid flops and output
//   valid; the slot memory itself is not cleared
module selective_repeat_receiver #(
  parameter int WINDOW = 16
) (
  input logic      clk,
  input logic      rst_n,
  srr_in_if.sink   in_chan,
  srr_out_if.source out_chan
);
  import srr_pkg::*;

  localparam int IDXW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  srr_state_t state_r, state_nxt;

  logic [SEQ_W-1:0]        seq_r, seq_nxt;
  logic signed [CKS_W-1:0] ack_r, ack_nxt;
  logic signed [CKS_W-1:0] cks_r, cks_nxt;
  logic [WORD_W-1:0]       plo_r, plo_nxt;
  logic [WORD_W-1:0]       pmid_r, pmid_nxt;
  logic [HIGH_W-1:0]       phi_r, phi_nxt;
  logic signed [PART_W-1:0] part_r, part_nxt;
  logic [CKS_W-1:0]        seqack_r, seqack_nxt;

  logic [SEQ_W-1:0]        expected_r, expected_nxt;
  logic [IDXW-1:0]         base_r, base_nxt;
  logic [WINDOW-1:0]       slot_valid_r, slot_valid_nxt;
  srr_kind_t               first_kind_r, first_kind_nxt;
  logic                    first_last_r, first_last_nxt;

  logic                    out_valid_r, out_valid_nxt;
  srr_kind_t               out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]        out_seq_r, out_seq_nxt;
  logic [CKS_W-1:0]        out_cks_r, out_cks_nxt;
  logic [WORD_W-1:0]       out_lo_r, out_lo_nxt;
  logic [WORD_W-1:0]       out_mid_r, out_mid_nxt;
  logic [HIGH_W-1:0]       out_hi_r, out_hi_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [SLOT_W-1:0]       slot_mem [WINDOW];
  logic [SLOT_W-1:0]       rd_data_r;
  logic                    mem_we;
  logic [IDXW-1:0]         mem_waddr;

  logic                    in_take;
  logic                    can_push;
  logic [CKS_W-1:0]        total;
  logic                    good;
  logic [SEQ_W-1:0]        seq_ofs;
  logic                    in_win;
  logic [IDXW:0]           phys_sum;
  logic [IDXW-1:0]         phys;
  logic                    is_new;
  logic [IDXW-1:0]         base_inc;

  assign in_take  = in_chan.valid && (state_r == ST_IDLE);
  assign can_push = !out_valid_r || out_chan.ready;

  assign total   = seqack_r + CKS_W'(part_r);
  assign good    = (total == cks_r);
  assign seq_ofs = seq_r - expected_r;
  assign in_win  = (seq_ofs < SEQ_W'(WINDOW));

  assign phys_sum = {1'b0, base_r} + {1'b0, seq_ofs[IDXW-1:0]};
  assign phys     = (phys_sum >= (IDXW+1)'(WINDOW)) ?
                    IDXW'(phys_sum - (IDXW+1)'(WINDOW)) : phys_sum[IDXW-1:0];
  assign is_new   = !slot_valid_r[phys];
  assign base_inc = (base_r == IDXW'(WINDOW - 1)) ? '0 : base_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    seq_nxt        = seq_r;
    ack_nxt        = ack_r;
    cks_nxt        = cks_r;
    plo_nxt        = plo_r;
    pmid_nxt       = pmid_r;
    phi_nxt        = phi_r;
    part_nxt       = part_r;
    seqack_nxt     = seqack_r;
    expected_nxt   = expected_r;
    base_nxt       = base_r;
    slot_valid_nxt = slot_valid_r;
    first_kind_nxt = first_kind_r;
    first_last_nxt = first_last_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_kind_nxt   = out_kind_r;
    out_seq_nxt    = out_seq_r;
    out_cks_nxt    = out_cks_r;
    out_lo_nxt     = out_lo_r;
    out_mid_nxt    = out_mid_r;
    out_hi_nxt     = out_hi_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = phys;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          seq_nxt   = in_chan.seq_number;
          ack_nxt   = in_chan.ack_number;
          cks_nxt   = in_chan.packet_checksum;
          plo_nxt   = in_chan.payload_low;
          pmid_nxt  = in_chan.payload_mid;
          phi_nxt   = in_chan.payload_high;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        part_nxt   = byte_sum8(plo_r) + byte_sum8(pmid_r) + byte_sum4(phi_r);
        seqack_nxt = CKS_W'(seq_r) + ack_r;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (!good) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_FIRST;
          if (in_win) begin
            first_kind_nxt = KIND_ACK;
            first_last_nxt = !(is_new && (seq_ofs == '0));
            if (is_new) begin
              mem_we               = 1'b1;
              slot_valid_nxt[phys] = 1'b1;
            end
          end else begin
            first_kind_nxt = (seq_r < expected_r) ? KIND_ACK : KIND_DROP;
            first_last_nxt = 1'b1;
          end
        end
      end
      ST_FIRST: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = first_kind_r;
          out_seq_nxt   = seq_r;
          out_cks_nxt   = (first_kind_r == KIND_ACK) ? CKS_W'(seq_r) + 1'b1 : '0;
          out_lo_nxt    = '0;
          out_mid_nxt   = '0;
          out_hi_nxt    = '0;
          out_last_nxt  = first_last_r;
          state_nxt     = first_last_r ? ST_IDLE : ST_DLV;
        end
      end
      ST_DLV: begin
        if (can_push) begin
          out_valid_nxt          = 1'b1;
          out_kind_nxt           = KIND_DATA;
          out_seq_nxt            = expected_r;
          out_cks_nxt            = '0;
          out_lo_nxt             = rd_data_r[WORD_W-1:0];
          out_mid_nxt            = rd_data_r[2*WORD_W-1:WORD_W];
          out_hi_nxt             = rd_data_r[SLOT_W-1:2*WORD_W];
          out_last_nxt           = !slot_valid_r[base_inc];
          slot_valid_nxt[base_r] = 1'b0;
          base_nxt               = base_inc;
          expected_nxt           = expected_r + 1'b1;
          state_nxt              = slot_valid_r[base_inc] ? ST_DLV : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      expected_r   <= '0;
      base_r       <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      expected_r   <= expected_nxt;
      base_r       <= base_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r        <= seq_nxt;
    ack_r        <= ack_nxt;
    cks_r        <= cks_nxt;
    plo_r        <= plo_nxt;
    pmid_r       <= pmid_nxt;
    phi_r        <= phi_nxt;
    part_r       <= part_nxt;
    seqack_r     <= seqack_nxt;
    first_kind_r <= first_kind_nxt;
    first_last_r <= first_last_nxt;
    out_kind_r   <= out_kind_nxt;
    out_seq_r    <= out_seq_nxt;
    out_cks_r    <= out_cks_nxt;
    out_lo_r     <= out_lo_nxt;
    out_mid_r    <= out_mid_nxt;
    out_hi_r     <= out_hi_nxt;
    out_last_r   <= out_last_nxt;
  end

  // slot memory, read address follows the next slot pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= {phi_r, pmid_r, plo_r};
    end
    rd_data_r <= slot_mem[base_nxt];
  end

  assign in_chan.ready             = (state_r == ST_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.result_kind      = out_kind_r;
  assign out_chan.result_seq       = out_seq_r;
  assign out_chan.ack_checksum     = out_cks_r;
  assign out_chan.out_payload_low  = out_lo_r;
  assign out_chan.out_payload_mid  = out_mid_r;
  assign out_chan.out_payload_high = out_hi_r;
  assign out_chan.last_of_run      = out_last_r;

  a_dlv_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DLV) |-> slot_valid_r[base_r])
    else $error("delivery from an empty slot");

  a_idle_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !slot_valid_r[base_r])
    else $error("in-order slot left undelivered");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= IDXW'(WINDOW - 1))
    else $error("slot pointer out of range");

  a_expected_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DLV && can_push) |=> (expected_r == $past(expected_r) + 1'b1))
    else $error("expected sequence did not advance on delivery");

  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIRST || state_r == ST_DLV) && out_valid_r && !out_chan.ready)
      |=> $stable(out_seq_r))
    else $error("held result overwritten");

endmodule

// ===== verif/tb_selective_repeat_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_receiver
// Drives good, corrupt, stale, duplicate and out-of-window packets into the
// receiver with random stalls on both channels. A packet-level model of the
// reorder window predicts every acknowledgement, delivery and drop, and each
// result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_selective_repeat_receiver;
  import srr_pkg::*;

  localparam int WINDOW        = 16;
  localparam int IDX_W         = $clog2(WINDOW);
  localparam int PAYLOAD_BYTES = 20;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int TOTAL_PKTS    = 500;
  localparam int QUEUE_DEPTH   = 32;
  localparam int IDLE_PCT      = 22;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [CKS_W-1:0]  ack;
    logic [CKS_W-1:0]  cks;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] mid;
    logic [HIGH_W-1:0] hi;
  } packet_t;

  typedef struct packed {
    srr_kind_t         kind;
    logic [SEQ_W-1:0]  seq;
    logic [CKS_W-1:0]  cks;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] mid;
    logic [HIGH_W-1:0] hi;
    logic              last;
  } result_t;

  logic clk;
  logic rst_n;

  srr_in_if  in_ch ();
  srr_out_if out_ch ();

  selective_repeat_receiver #(
    .WINDOW (WINDOW)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  packet_t pending_pkts[$];
  result_t expected_results[$];
  packet_t cur_pkt;

  // receive window model
  logic [SEQ_W-1:0]  rx_next_seq;
  logic              rx_held [WINDOW];
  logic [WORD_W-1:0] rx_lo   [WINDOW];
  logic [WORD_W-1:0] rx_mid  [WINDOW];
  logic [HIGH_W-1:0] rx_hi   [WINDOW];

  int pkts_queued;
  int pkts_taken;
  int results_seen;
  int mismatches;
  int cycle_count;
  int hold_left;
  bit hold_done;

  initial begin
    clk = 1'b0;
  end

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [CKS_W-1:0] packet_sum(input packet_t p);
    logic [CKS_W-1:0]           s;
    logic [8*PAYLOAD_BYTES-1:0] bytes;
    bytes = {p.hi, p.mid, p.lo};
    s = {1'b0, p.seq} + p.ack;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      s = s + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
    end
    return s;
  endfunction

  function automatic packet_t make_pkt(input logic [SEQ_W-1:0] seq,
                                       input logic [CKS_W-1:0] ack,
                                       input logic [WORD_W-1:0] lo,
                                       input logic [WORD_W-1:0] mid,
                                       input logic [HIGH_W-1:0] hi);
    packet_t p;
    p.seq = seq;
    p.ack = ack;
    p.lo  = lo;
    p.mid = mid;
    p.hi  = hi;
    p.cks = packet_sum(p);
    return p;
  endfunction

  function automatic packet_t rand_pkt(input logic [SEQ_W-1:0] seq);
    return make_pkt(seq, CKS_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                    HIGH_W'($urandom));
  endfunction

  function automatic void add_expected(input result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void predict_packet(input packet_t p);
    logic [SEQ_W-1:0] seq_ofs;
    logic [IDX_W-1:0] slot;
    result_t          r;
    if (packet_sum(p) != p.cks) begin
      return;
    end
    r = '0;
    r.seq = p.seq;
    seq_ofs = p.seq - rx_next_seq;
    if (seq_ofs >= SEQ_W'(WINDOW)) begin
      if (p.seq < rx_next_seq) begin
        r.kind = KIND_ACK;
        r.cks  = {1'b0, p.seq} + CKS_W'(1);
      end else begin
        r.kind = KIND_DROP;
      end
      r.last = 1'b1;
      add_expected(r);
      return;
    end
    slot = seq_ofs[IDX_W-1:0];
    r.kind = KIND_ACK;
    r.cks  = {1'b0, p.seq} + CKS_W'(1);
    if (!rx_held[slot]) begin
      rx_held[slot] = 1'b1;
      rx_lo[slot]   = p.lo;
      rx_mid[slot]  = p.mid;
      rx_hi[slot]   = p.hi;
      while (rx_held[0]) begin
        add_expected(r);
        r = '0;
        r.kind = KIND_DATA;
        r.seq  = rx_next_seq;
        r.lo   = rx_lo[0];
        r.mid  = rx_mid[0];
        r.hi   = rx_hi[0];
        for (int i = 0; i < WINDOW - 1; i++) begin
          rx_held[i] = rx_held[i+1];
          rx_lo[i]   = rx_lo[i+1];
          rx_mid[i]  = rx_mid[i+1];
          rx_hi[i]   = rx_hi[i+1];
        end
        rx_held[WINDOW-1] = 1'b0;
        rx_next_seq = rx_next_seq + SEQ_W'(1);
      end
    end
    r.last = 1'b1;
    add_expected(r);
  endfunction

  task automatic queue_pkt(input packet_t p);
    while (pending_pkts.size() >= QUEUE_DEPTH) @(negedge clk);
    pending_pkts = {pending_pkts, p};
    pkts_queued++;
  endtask

  task automatic wait_drained();
    while (pending_pkts.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // packet driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_packet(cur_pkt);
        pkts_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pkts.size() != 0 &&
            ((pkts_taken >= 250 && pkts_taken < 330) || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_pkt = pending_pkts.pop_front();
          in_ch.seq_number      <= cur_pkt.seq;
          in_ch.ack_number      <= cur_pkt.ack;
          in_ch.packet_checksum <= cur_pkt.cks;
          in_ch.payload_low     <= cur_pkt.lo;
          in_ch.payload_mid     <= cur_pkt.mid;
          in_ch.payload_high    <= cur_pkt.hi;
          in_ch.valid           <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d unexpected: kind %0d seq %0h cks %0h last %0b",
                     results_seen, out_ch.result_kind, out_ch.result_seq,
                     out_ch.ack_checksum, out_ch.last_of_run);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_kind !== want.kind || out_ch.result_seq !== want.seq ||
              out_ch.ack_checksum !== want.cks || out_ch.out_payload_low !== want.lo ||
              out_ch.out_payload_mid !== want.mid || out_ch.out_payload_high !== want.hi ||
              out_ch.last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d expected: kind %0d seq %0h cks %0h data %0h_%0h_%0h last %0b",
                       results_seen, want.kind, want.seq, want.cks,
                       want.hi, want.mid, want.lo, want.last);
              $display("result %0d actual:   kind %0d seq %0h cks %0h data %0h_%0h_%0h last %0b",
                       results_seen, out_ch.result_kind, out_ch.result_seq,
                       out_ch.ack_checksum, out_ch.out_payload_high, out_ch.out_payload_mid,
                       out_ch.out_payload_low, out_ch.last_of_run);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        // long backpressure so the block fills and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (results_seen >= 450 && results_seen < 620) ||
                        $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [SEQ_W-1:0] base;
    int               order [WINDOW];
    int               round_len;
    int               pick;
    int               tmp;
    bit               paused_mid;
    packet_t          p;

    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.seq_number      = '0;
    in_ch.ack_number      = '0;
    in_ch.packet_checksum = '0;
    in_ch.payload_low     = '0;
    in_ch.payload_mid     = '0;
    in_ch.payload_high    = '0;
    out_ch.ready          = 1'b0;
    rx_next_seq           = '0;
    foreach (rx_held[i]) rx_held[i] = 1'b0;
    paused_mid = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corrupt header, all payload bytes negative
    p = make_pkt('0, 32'h8000_0000, '1, '1, '1);
    p.cks = ~p.cks;
    queue_pkt(p);
    // in order, byte extremes
    queue_pkt(make_pkt('0, 32'h7FFF_FFFF, {8{8'h80}}, {8{8'h7F}}, 32'h807F_01FF));
    // stale
    queue_pkt(make_pkt('0, '0, '0, '0, '0));
    // out of order, then duplicate, then the gap filler
    queue_pkt(rand_pkt(SEQ_W'(2)));
    queue_pkt(rand_pkt(SEQ_W'(2)));
    queue_pkt(rand_pkt(SEQ_W'(1)));
    // far edge of the window, first beyond it, top of the sequence space
    queue_pkt(rand_pkt(SEQ_W'(3 + WINDOW - 1)));
    queue_pkt(rand_pkt(SEQ_W'(3 + WINDOW)));
    queue_pkt(make_pkt('1, '1, '1, '0, '1));
    // fill the window backwards, then release it as one full run
    for (int s = 1 + WINDOW; s >= 4; s--) begin
      queue_pkt(rand_pkt(SEQ_W'(s)));
    end
    queue_pkt(rand_pkt(SEQ_W'(3)));
    wait_drained();

    // shuffled in-window rounds with corrupt, resent, stale and far packets mixed in
    base = rx_next_seq;
    while (pkts_queued < TOTAL_PKTS) begin
      round_len = $urandom_range(1, WINDOW);
      for (int i = 0; i < round_len; i++) begin
        order[i] = i;
      end
      for (int i = round_len - 1; i > 0; i--) begin
        pick = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[pick];
        order[pick] = tmp;
      end
      for (int i = 0; i < round_len; i++) begin
        p = rand_pkt(base + SEQ_W'(order[i]));
        queue_pkt(p);
        if ($urandom_range(0, 99) < 25) begin
          case ($urandom_range(0, 3))
            0: begin
              p.cks = p.cks ^ (CKS_W'($urandom) | CKS_W'(1));
              queue_pkt(p);
            end
            1: queue_pkt(p);
            2: queue_pkt(rand_pkt(SEQ_W'($urandom_range(0, 32'(base) - 1))));
            default: queue_pkt(rand_pkt(SEQ_W'($urandom)));
          endcase
        end
      end
      base = base + SEQ_W'(round_len);
      if (!paused_mid && pkts_queued >= TOTAL_PKTS / 2) begin
        paused_mid = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/srr_pkg.sv
sv/srr_if.sv
sv/selective_repeat_receiver.sv
verif/tb_selective_repeat_receiver.sv
